// ===== rtl/prank_pkg.sv =====
package prank_pkg;

  localparam int NUM_ELEMENTS = 9;
  localparam int NIB_W        = 4;
  localparam int TILES_W      = 36;
  localparam int RANK_W       = 19;
  localparam int STEP_W       = $clog2(NUM_ELEMENTS);
  localparam int STEPS        = NUM_ELEMENTS - 1;
  localparam int NUM_STAGES   = (STEPS + 1) / 2;
  localparam int PAD_W        = (NUM_ELEMENTS * NIB_W > TILES_W) ?
                                NUM_ELEMENTS * NIB_W : TILES_W;
  localparam int HIT_W        = 2 ** NIB_W;

  localparam logic [HIT_W-1:0] FULL_HIT = HIT_W'((64'd1 << NUM_ELEMENTS) - 64'd1);

  typedef logic [NUM_ELEMENTS-1:0][NIB_W-1:0]  elem_arr_t;
  typedef logic [NUM_ELEMENTS-1:0][RANK_W-1:0] place_tbl_t;

  typedef struct packed {
    elem_arr_t         elem;
    elem_arr_t         vals;
    elem_arr_t         where;
    logic [RANK_W-1:0] rank;
    logic              bad;
  } data_t;

  function automatic place_tbl_t build_place();
    place_tbl_t  tbl;
    logic [63:0] p;
    p = 64'd1;
    for (int k = 0; k < NUM_ELEMENTS; k++) begin
      tbl[k] = RANK_W'(p);
      p = p * 64'(NUM_ELEMENTS - k);
    end
    return tbl;
  endfunction

  localparam place_tbl_t PLACE = build_place();

endpackage

// ===== rtl/prank_stage.sv =====
module prank_stage (
  input  logic [prank_pkg::STEP_W-1:0] first_step_i,
  input  prank_pkg::data_t             data_i,
  output prank_pkg::data_t             data_o
);
  import prank_pkg::*;

  data_t             d;
  logic [STEP_W-1:0] s;
  logic [NIB_W-1:0]  pos;
  logic [NIB_W-1:0]  last;

  always_comb begin
    d    = data_i;
    s    = '0;
    pos  = '0;
    last = '0;
    for (int n = 0; n < 2; n++) begin
      s = first_step_i + STEP_W'(n);
      if (int'(s) < STEPS) begin
        pos = '0;
        for (int j = 0; j < NUM_ELEMENTS; j++) begin
          if (NIB_W'(j) == d.elem[s]) begin
            pos = d.where[j];
          end
        end
        last = '0;
        for (int j = 0; j < NUM_ELEMENTS; j++) begin
          if (j == NUM_ELEMENTS - 1 - int'(s)) begin
            last = d.vals[j];
          end
        end
        for (int j = 0; j < NUM_ELEMENTS; j++) begin
          if (NIB_W'(j) == pos) begin
            d.vals[j] = last;
          end
        end
        for (int j = 0; j < NUM_ELEMENTS; j++) begin
          if (NIB_W'(j) == last) begin
            d.where[j] = pos;
          end
        end
        d.rank = d.rank + RANK_W'(PLACE[s] * RANK_W'(pos));
      end
    end
    data_o = d;
  end

endmodule

// ===== rtl/permutation_rank_encoder.sv =====
// An accepted transaction passes through an input register, a range and duplicate check,
// one register stage per two swap steps, and an output register on its way to the result.
// Throughput: one transaction per cycle; the whole pipeline holds while the output stalls.
// Reset clears all valid bits; payload registers are not reset.
module permutation_rank_encoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [prank_pkg::TILES_W-1:0]   tiles_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [prank_pkg::RANK_W-1:0]    rank_o,
  output logic                            not_permutation_o
);
  import prank_pkg::*;

  logic                   adv;
  logic                   in_valid_q;
  logic [TILES_W-1:0]     tiles_q;
  logic                   chk_valid_q;
  data_t                  chk_d;
  data_t                  chk_q;
  logic [PAD_W-1:0]       padded;
  logic [HIT_W-1:0]       hit;
  logic [NUM_STAGES-1:0]  st_valid_q;
  data_t                  st_in  [NUM_STAGES];
  data_t                  st_d   [NUM_STAGES];
  data_t                  st_q   [NUM_STAGES];
  logic                   out_valid_q;
  logic [RANK_W-1:0]      rank_q;
  logic                   bad_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  always_comb begin
    padded = PAD_W'(tiles_q);
    hit    = '0;
    chk_d  = '0;
    for (int i = 0; i < NUM_ELEMENTS; i++) begin
      chk_d.elem[i]  = padded[i*NIB_W +: NIB_W];
      chk_d.vals[i]  = NIB_W'(i);
      chk_d.where[i] = NIB_W'(i);
      hit = hit | (HIT_W'(1) << chk_d.elem[i]);
    end
    chk_d.bad = (hit != FULL_HIT);
  end

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign st_in[k] = chk_q;
    end else begin : g_next
      assign st_in[k] = st_q[k-1];
    end
    prank_stage u_stage (
      .first_step_i (STEP_W'(2 * k)),
      .data_i       (st_in[k]),
      .data_o       (st_d[k])
    );
    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      chk_valid_q <= 1'b0;
      st_valid_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      in_valid_q  <= in_valid_i;
      chk_valid_q <= in_valid_q;
      st_valid_q  <= NUM_STAGES'({st_valid_q, chk_valid_q});
      out_valid_q <= st_valid_q[NUM_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tiles_q <= tiles_i;
      chk_q   <= chk_d;
      rank_q  <= st_q[NUM_STAGES-1].bad ? '0 : st_q[NUM_STAGES-1].rank;
      bad_q   <= st_q[NUM_STAGES-1].bad;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign rank_o            = rank_q;
  assign not_permutation_o = bad_q;

endmodule
